### src/glct_pkg.sv
package glct_pkg;

	localparam int COORD_BITS = 5;
	// signed working width: holds the cube z coordinate, its delta and doubled errors
	localparam int VAL_BITS   = COORD_BITS + 3;
	// step count: up to twice the coordinate span
	localparam int CNT_BITS   = COORD_BITS + 1;
	localparam int LAYER_BITS = 4;
	localparam int NUM_COMP   = 3;

	// cube component slots
	localparam int CX = 0;
	localparam int CY = 1;
	localparam int CZ = 2;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [VAL_BITS-1:0]   sval_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;
	typedef logic [LAYER_BITS-1:0]        layer_t;

	localparam sval_t S_ZERO = sval_t'(0);
	localparam sval_t S_ONE  = sval_t'(1);
	localparam sval_t S_MONE = sval_t'(-1);
	localparam cnt_t  CNT_ONE = cnt_t'(1);

	typedef struct packed {
		coord_t from_x;
		coord_t from_y;
		layer_t from_layer;
		coord_t to_x;
		coord_t to_y;
		layer_t to_layer;
	} in_word_t;

	typedef struct packed {
		coord_t cell_x;
		coord_t cell_y;
		layer_t cell_layer;
		logic   empty_res;
		logic   swapped;
		logic   last;
	} out_word_t;

	// one cube component: value = base + rem / steps, advanced by delta / steps
	typedef struct packed {
		sval_t base;
		cnt_t  rem;
		sval_t delta;
	} comp_t;

	typedef struct packed {
		logic  hex;
		sval_t cur_x;
		sval_t cur_y;
		sval_t end_x;
		sval_t end_y;
		sval_t err;
		cnt_t  steps;
		cnt_t  st;
	} step_ctl_t;

	typedef struct packed {
		sval_t cand_x;
		sval_t cand_y;
		sval_t err_nx;
		logic  done;
		logic  emit;
	} step_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	function automatic sval_t abs_s(sval_t v);
		return v[VAL_BITS-1] ? -v : v;
	endfunction

endpackage

### src/glct_step.sv
module glct_step (
	input  glct_pkg::step_ctl_t ctl,
	input  glct_pkg::comp_t     comp    [glct_pkg::NUM_COMP],
	output glct_pkg::step_res_t res,
	output glct_pkg::comp_t     comp_nx [glct_pkg::NUM_COMP]
);
	import glct_pkg::*;

	typedef struct packed {
		sval_t rnd;
		cnt_t  err;
	} rnd_t;

	// add delta to the remainder, one wrap either way since |delta| <= steps
	function automatic comp_t comp_adv(comp_t c, cnt_t steps);
		sval_t stp;
		sval_t sum;
		comp_t n;
		stp = sval_t'(steps);
		sum = sval_t'(c.rem) + c.delta;
		n = c;
		if (sum >= stp) begin
			n.rem  = cnt_t'(sum - stp);
			n.base = c.base + S_ONE;
		end else if (sum < S_ZERO) begin
			n.rem  = cnt_t'(sum + stp);
			n.base = c.base - S_ONE;
		end else begin
			n.rem  = cnt_t'(sum);
		end
		return n;
	endfunction

	// nearest integer, half away from zero; a tie has rem > 0 so sign of base decides
	function automatic rnd_t comp_round(comp_t c, cnt_t steps);
		logic [CNT_BITS:0] twice;
		logic [CNT_BITS:0] full;
		logic              up;
		rnd_t              r;
		twice = {c.rem, 1'b0};
		full  = {1'b0, steps};
		up    = (twice > full) || ((twice == full) && !c.base[VAL_BITS-1]);
		r.rnd = up ? c.base + S_ONE : c.base;
		r.err = up ? steps - c.rem : c.rem;
		return r;
	endfunction

	rnd_t  rq [NUM_COMP];
	sval_t rx, ry;
	sval_t ax, ay, d2, stx, sty, qx, qy;
	logic  go_x, go_y;

	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			comp_nx[i] = comp_adv(comp[i], ctl.steps);
			rq[i]      = comp_round(comp_nx[i], ctl.steps);
		end

		// hex: recompute the component with the largest rounding error
		rx = rq[CX].rnd;
		ry = rq[CY].rnd;
		if (rq[CX].err > rq[CY].err && rq[CX].err > rq[CZ].err) begin
			rx = -rq[CY].rnd - rq[CZ].rnd;
		end else if (rq[CY].err > rq[CZ].err) begin
			ry = -rq[CX].rnd - rq[CZ].rnd;
		end

		// square: one Bresenham step, deltas shared with the x and y slots
		ax   = abs_s(comp[CX].delta);
		ay   = abs_s(comp[CY].delta);
		stx  = comp[CX].delta[VAL_BITS-1] ? S_MONE :
		       (comp[CX].delta == S_ZERO) ? S_ZERO : S_ONE;
		sty  = comp[CY].delta[VAL_BITS-1] ? S_MONE :
		       (comp[CY].delta == S_ZERO) ? S_ZERO : S_ONE;
		d2   = ctl.err <<< 1;
		go_x = d2 > -ay;
		go_y = d2 < ax;
		qx   = ctl.cur_x + (go_x ? stx : S_ZERO);
		qy   = ctl.cur_y + (go_y ? sty : S_ZERO);

		if (ctl.hex) begin
			res.cand_x = rx;
			res.cand_y = ry;
			res.err_nx = ctl.err;
			res.done   = ctl.st >= ctl.steps;
			res.emit   = (rx != ctl.cur_x) || (ry != ctl.cur_y);
		end else begin
			res.cand_x = qx;
			res.cand_y = qy;
			res.err_nx = ctl.err - (go_x ? ay : S_ZERO) + (go_y ? ax : S_ZERO);
			res.done   = (qx == ctl.end_x) && (qy == ctl.end_y);
			res.emit   = 1'b1;
		end
	end

endmodule

### src/grid_line_cell_trace.sv
// grid_line_cell_trace: takes a pair of cells and returns, one word per cell, the cells
// that lie strictly between them, in order from the lower cell (smaller x, then smaller
// y) to the higher; swapped flags a pair given the other way round. With hex_mode clear
// the walk is the 8-connected Bresenham line; with it set the cells are axial hex
// coordinates and the trace follows the cube line, rounding each component to the
// nearest hex and dropping repeats. Cells on different layers, or a pair with nothing
// between them, give a single word with empty_res set. The final word of each pair has
// last set. Timing: one pair is worked at a time and in_ready is low from acceptance
// until the final word has been loaded into the output register. One cell step is
// taken per clock by the shared step unit while the output is not stalled; a stalled
// output holds the walk. hex_mode may only be written while no pair is in progress.
module grid_line_cell_trace (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  glct_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output glct_pkg::out_word_t  out_word,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data
);
	import glct_pkg::*;

	state_t    state_q, state_nx;
	out_word_t out_q, push_word;
	logic      out_valid_q;
	logic      hex_mode_q;
	logic      pend_q;          // cur holds a cell not yet sent
	logic      sw_q;
	layer_t    layer_q;
	sval_t     cur_x_q, cur_y_q, end_x_q, end_y_q, err_q;
	cnt_t      steps_q, st_q;
	comp_t     comp_q  [NUM_COMP];
	comp_t     comp_nx [NUM_COMP];

	step_ctl_t ctl;
	step_res_t res;

	logic      in_acc, out_free, adv, push, push_last;

	// set-up of a new pair
	logic      swap, same_layer;
	coord_t    sx, sy, ex, ey;
	sval_t     dq, dr, dz, az, mx, err_init;

	always_comb begin
		swap = (in_word.to_x < in_word.from_x) ||
		       ((in_word.to_x == in_word.from_x) && (in_word.to_y < in_word.from_y));
		same_layer = in_word.from_layer == in_word.to_layer;
		sx = swap ? in_word.to_x   : in_word.from_x;
		sy = swap ? in_word.to_y   : in_word.from_y;
		ex = swap ? in_word.from_x : in_word.to_x;
		ey = swap ? in_word.from_y : in_word.to_y;
		dq = sval_t'(ex) - sval_t'(sx);
		dr = sval_t'(ey) - sval_t'(sy);
		dz = -dq - dr;
		az = -sval_t'(sx) - sval_t'(sy);
		mx = abs_s(dq);
		if (abs_s(dr) > mx) begin
			mx = abs_s(dr);
		end
		if (abs_s(dz) > mx) begin
			mx = abs_s(dz);
		end
		err_init = abs_s(dq) - abs_s(dr);
	end

	always_comb begin
		ctl.hex   = hex_mode_q;
		ctl.cur_x = cur_x_q;
		ctl.cur_y = cur_y_q;
		ctl.end_x = end_x_q;
		ctl.end_y = end_y_q;
		ctl.err   = err_q;
		ctl.steps = steps_q;
		ctl.st    = st_q;
	end

	glct_step u_step (
		.ctl     (ctl),
		.comp    (comp_q),
		.res     (res),
		.comp_nx (comp_nx)
	);

	assign in_ready  = state_q == ST_IDLE;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// sequencer
	always_comb begin
		state_nx  = state_q;
		adv       = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = same_layer ? ST_RUN : ST_FINISH;
				end
			end
			ST_RUN: begin
				if (res.done) begin
					state_nx = ST_FINISH;
				end else if (!res.emit || !pend_q || out_free) begin
					// a new cell pushes the one held before it
					adv  = 1'b1;
					push = res.emit && pend_q;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// held cell, or the empty word when nothing was found
	always_comb begin
		push_word.cell_x     = pend_q ? cur_x_q[COORD_BITS-1:0] : '0;
		push_word.cell_y     = pend_q ? cur_y_q[COORD_BITS-1:0] : '0;
		push_word.cell_layer = pend_q ? layer_q : '0;
		push_word.empty_res  = !pend_q;
		push_word.swapped    = sw_q;
		push_word.last       = push_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hex_mode_q  <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				hex_mode_q <= cfg_wr_data;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc || push_last) begin
				pend_q <= 1'b0;
			end else if (adv && res.emit) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= push_word;
		end
		if (in_acc) begin
			cur_x_q  <= sval_t'(sx);
			cur_y_q  <= sval_t'(sy);
			end_x_q  <= sval_t'(ex);
			end_y_q  <= sval_t'(ey);
			err_q    <= err_init;
			steps_q  <= cnt_t'(mx);
			st_q     <= CNT_ONE;
			layer_q  <= in_word.from_layer;
			sw_q     <= swap && same_layer;
			comp_q[CX].base  <= sval_t'(sx);
			comp_q[CX].rem   <= '0;
			comp_q[CX].delta <= dq;
			comp_q[CY].base  <= sval_t'(sy);
			comp_q[CY].rem   <= '0;
			comp_q[CY].delta <= dr;
			comp_q[CZ].base  <= az;
			comp_q[CZ].rem   <= '0;
			comp_q[CZ].delta <= dz;
		end else if (adv) begin
			st_q  <= cnt_t'(st_q + CNT_ONE);
			err_q <= res.err_nx;
			for (int i = 0; i < NUM_COMP; i++) begin
				comp_q[i] <= comp_nx[i];
			end
			if (res.emit) begin
				cur_x_q <= res.cand_x;
				cur_y_q <= res.cand_y;
			end
		end
	end

endmodule

### src/glct_check.sv
module glct_check (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input glct_pkg::out_word_t out_word
);
	import glct_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// an empty word is the only word of its pair and carries no cell
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.empty_res |-> out_word.last && out_word.cell_x == '0 &&
		out_word.cell_y == '0 && out_word.cell_layer == '0)
		else $error("empty word not final or not cleared");

	// one pair at a time
	a_one_pair: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new pair taken while busy");

	// a word before the final one means the pair is still in progress
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last |-> !in_ready)
		else $error("ready while a pair is unfinished");

endmodule

bind grid_line_cell_trace glct_check u_glct_check (.*);

### tb/sv/grid_line_cell_trace_tb.sv
module grid_line_cell_trace_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import glct_pkg::*;

	// hex_mode register settings
	localparam logic MODE_SQUARE = 1'b0;
	localparam logic MODE_HEX    = 1'b1;

	// Slowest legal run: about 130 pairs, each up to 61 words, with 35 % output stalls.
	// The limit covers the time that this needs many times over.
	localparam int CYC_LIMIT  = 400000;
	// ample for a stray word of the last pair to show
	localparam int DRAIN_CYC  = 80;
	localparam int SETTLE_CYC = 8;

	logic      clk         = 1'b0;
	logic      arst_n      = 1'b0;
	logic      in_valid    = 1'b0;
	logic      in_ready;
	in_word_t  in_word     = '0;
	logic      out_valid;
	logic      out_ready   = 1'b0;
	out_word_t out_word;
	logic      cfg_wr_en   = 1'b0;
	logic      cfg_wr_data = 1'b0;

	in_word_t  pair_q[$];   // pairs waiting to be offered
	out_word_t cell_q[$];   // predicted cell words, oldest first
	logic      hex_sel       = MODE_SQUARE;  // our copy of hex_mode
	int        in_idle_pct   = 35;
	int        out_stall_pct = 35;
	int        fail_cnt      = 0;
	int        cyc_cnt       = 0;

	grid_line_cell_trace u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #1 clk = ~clk;

	function automatic int iabs(int v);
		return (v < 0) ? -v : v;
	endfunction

	// nearest integer to n/s, halves away from zero (s > 0)
	function automatic int round_near(int n, int s);
		if (n >= 0) begin
			return (2 * n + s) / (2 * s);
		end
		return -((-2 * n + s) / (2 * s));
	endfunction

	function automatic out_word_t cell_word(int x, int y, layer_t lyr, logic emp, logic sw);
		out_word_t o;
		o.cell_x     = coord_t'(x);
		o.cell_y     = coord_t'(y);
		o.cell_layer = lyr;
		o.empty_res  = emp;
		o.swapped    = sw;
		o.last       = 1'b0;
		return o;
	endfunction

	// Works out the interior cells of one pair and appends their words to cell_q.
	function automatic void trace_cells(in_word_t w, logic hex);
		out_word_t seq[$];
		int sx, sy, ex, ey;
		int dq, dr, dz, az, steps, px, py;
		int nx, ny, nz, rx, ry, rz, err_x, err_y, err_z;
		int stx, sty, ax, ay, x, y, err, d2;
		logic sw;

		sw = 1'b0;
		if (w.from_layer == w.to_layer) begin
			sx = w.from_x;
			sy = w.from_y;
			ex = w.to_x;
			ey = w.to_y;
			// canonical order: smaller x first, then smaller y
			if (ex < sx || (ex == sx && ey < sy)) begin
				sw = 1'b1;
				sx = w.to_x;
				sy = w.to_y;
				ex = w.from_x;
				ey = w.from_y;
			end
			if (hex == MODE_HEX) begin
				dq = ex - sx;
				dr = ey - sy;
				dz = -dq - dr;
				az = -sx - sy;
				steps = iabs(dq);
				if (iabs(dr) > steps) steps = iabs(dr);
				if (iabs(dz) > steps) steps = iabs(dz);
				px = sx;
				py = sy;
				// components kept exact as numerators over steps
				for (int st = 1; st < steps; st++) begin
					nx = sx * steps + dq * st;
					ny = sy * steps + dr * st;
					nz = az * steps + dz * st;
					rx = round_near(nx, steps);
					ry = round_near(ny, steps);
					rz = round_near(nz, steps);
					err_x = iabs(rx * steps - nx);
					err_y = iabs(ry * steps - ny);
					err_z = iabs(rz * steps - nz);
					// x fixed only if strictly worst; otherwise y over z, z on a tie
					if (err_x > err_y && err_x > err_z) begin
						rx = -ry - rz;
					end else if (err_y > err_z) begin
						ry = -rx - rz;
					end
					if (rx != px || ry != py) begin
						seq = {seq, cell_word(rx, ry, w.from_layer, 1'b0, sw)};
						px = rx;
						py = ry;
					end
				end
			end else begin
				dx_dy: begin
					stx = (ex > sx) ? 1 : ((ex < sx) ? -1 : 0);
					sty = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
					ax  = iabs(ex - sx);
					ay  = iabs(ey - sy);
					x   = sx;
					y   = sy;
					err = ax - ay;
				end
				while (x != ex || y != ey) begin
					d2 = 2 * err;
					// both tests passing gives a diagonal step
					if (d2 > -ay) begin
						err -= ay;
						x += stx;
					end
					if (d2 < ax) begin
						err += ax;
						y += sty;
					end
					if (x == ex && y == ey) break;
					seq = {seq, cell_word(x, y, w.from_layer, 1'b0, sw)};
				end
			end
		end
		// no interior (or layers differ): a single empty word, swapped clear on a layer clash
		if (seq.size() == 0) begin
			seq = {seq, cell_word(0, 0, '0, 1'b1, sw)};
		end
		seq[seq.size() - 1].last = 1'b1;
		cell_q = {cell_q, seq};
	endfunction

	function automatic in_word_t rand_pair();
		in_word_t w;
		w.from_x     = coord_t'($urandom);
		w.from_y     = coord_t'($urandom);
		w.from_layer = layer_t'($urandom);
		// mostly same layer so that real traces dominate
		w.to_layer   = ($urandom_range(99) < 20) ? layer_t'($urandom) : w.from_layer;
		if ($urandom_range(99) < 30) begin
			// close pairs: equal, adjacent and short lines, wrapped at the edges
			w.to_x = w.from_x + coord_t'($urandom_range(6)) - coord_t'(3);
			w.to_y = w.from_y + coord_t'($urandom_range(6)) - coord_t'(3);
		end else begin
			w.to_x = coord_t'($urandom);
			w.to_y = coord_t'($urandom);
		end
		return w;
	endfunction

	task automatic push_pair(int fx, int fy, int fl, int tx, int ty, int tl);
		in_word_t w;
		w.from_x     = coord_t'(fx);
		w.from_y     = coord_t'(fy);
		w.from_layer = layer_t'(fl);
		w.to_x       = coord_t'(tx);
		w.to_y       = coord_t'(ty);
		w.to_layer   = layer_t'(tl);
		pair_q = {pair_q, w};
	endtask

	// register write; only called with the block idle
	task automatic set_mode(logic m);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		hex_sel     <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// every pair offered and every word back, then a short settle
	task automatic wait_idle();
		while (pair_q.size() != 0 || cell_q.size() != 0 || in_valid) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic run_random(int n, logic m, int pct);
		set_mode(m);
		@(negedge clk);
		in_idle_pct   = pct;
		out_stall_pct = pct;
		repeat (n) pair_q = {pair_q, rand_pair()};
		wait_idle();
	endtask

	// Driver: offers pair_q[0], holds it until taken, predicts the trace on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				trace_cells(in_word, hex_sel);
				void'(pair_q.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (pair_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_word  <= pair_q[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each word taken is checked against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : mon
		out_word_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (cell_q.size() == 0) begin
					$error("unexpected word: cell_x %0d cell_y %0d empty_res %0b",
						out_word.cell_x, out_word.cell_y, out_word.empty_res);
					fail_cnt++;
				end else begin
					want = cell_q.pop_front();
					if (out_word.cell_x !== want.cell_x) begin
						$error("cell_x: expected %0d, got %0d", want.cell_x, out_word.cell_x);
						fail_cnt++;
					end
					if (out_word.cell_y !== want.cell_y) begin
						$error("cell_y: expected %0d, got %0d", want.cell_y, out_word.cell_y);
						fail_cnt++;
					end
					if (out_word.cell_layer !== want.cell_layer) begin
						$error("cell_layer: expected %0d, got %0d",
							want.cell_layer, out_word.cell_layer);
						fail_cnt++;
					end
					if (out_word.empty_res !== want.empty_res) begin
						$error("empty_res: expected %0b, got %0b",
							want.empty_res, out_word.empty_res);
						fail_cnt++;
					end
					if (out_word.swapped !== want.swapped) begin
						$error("swapped: expected %0b, got %0b", want.swapped, out_word.swapped);
						fail_cnt++;
					end
					if (out_word.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, out_word.last);
						fail_cnt++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt >= CYC_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed set, once per grid mode.
		for (int m = 0; m < 2; m++) begin
			set_mode(m ? MODE_HEX : MODE_SQUARE);
			@(negedge clk);
			push_pair( 0,  0,  0,  0,  0,  0);  // same cell: empty word
			push_pair( 5,  5,  3,  6,  6,  3);  // adjacent diagonal: empty word in square mode
			push_pair( 0,  0,  0, 31, 31,  0);  // full diagonal, longest hex trace
			push_pair(31, 31, 15,  0,  0, 15);  // same reversed, top layer
			push_pair( 0, 31,  7, 31,  0,  7);  // anti-diagonal, hex dz is zero
			push_pair(31,  0,  2,  0, 31,  2);  // anti-diagonal reversed
			push_pair(10, 20,  1, 10,  3,  1);  // same x, y falling: swapped by y
			push_pair( 0, 12,  4, 31, 12,  4);  // horizontal
			push_pair( 3,  1,  9,  8, 28,  9);  // steep
			push_pair( 2,  4,  5, 29, 11,  5);  // shallow
			push_pair(20, 20,  1,  4,  4,  2);  // layers differ: swapped stays clear
			push_pair( 7,  9,  6,  9, 10,  6);  // short, rounding ties in hex
			wait_idle();
		end

		// Random part; third phase runs with no idling on either side.
		run_random(27, MODE_HEX,    35);
		run_random(27, MODE_SQUARE, 35);
		run_random(27, MODE_HEX,    0);
		run_random(27, MODE_SQUARE, 35);

		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
